// ===== rtl/jds_pkg.sv =====
// shared types, constants and register codes of the jukebox drive selector
package jds_pkg;

    localparam int MAX_DRIVES_DEF = 16;

    localparam int DRV_W      = 4;
    localparam int MASK_W     = 16;
    localparam int ELEM_W     = 16;
    localparam int TIME_W     = 32;
    localparam int SECS_W     = 16;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] DRIVE_COUNT_RST = 5'd16;
    localparam logic [MASK_W-1:0]  PRESENT_RST     = 16'hFFFF;
    localparam logic [MASK_W-1:0]  OFFLINE_RST     = 16'h0000;
    localparam logic [SECS_W-1:0]  HYST_RST        = 16'd10;
    localparam logic [SECS_W-1:0]  TIMEOUT_RST     = 16'd600;

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_EMPTY = 3'd1,
        ST_EVICT = 3'd2,
        ST_WAIT  = 3'd3,
        ST_PROBE = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_COUNT = 3'd0,
        CFG_PRESENT     = 3'd1,
        CFG_OFFLINE     = 3'd2,
        CFG_HYST        = 3'd3,
        CFG_TIMEOUT     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] drive_count;
        logic [MASK_W-1:0]  present;
        logic [MASK_W-1:0]  offline;
        logic [SECS_W-1:0]  hyst;
        logic [SECS_W-1:0]  timeout;
    } cfg_t;

    typedef struct packed {
        logic               touch;
        logic               load;
        logic [DRV_W-1:0]   idx;
        logic [MASK_W-1:0]  unload;
        logic [ELEM_W-1:0]  elem;
        logic               flip;
        logic [TIME_W-1:0]  now;
    } tbl_upd_t;

    typedef struct packed {
        status_t            status;
        logic [DRV_W-1:0]   drive_index;
        logic               evicted_valid;
        logic [ELEM_W-1:0]  evicted_element;
        logic               evicted_flip;
        logic [MASK_W-1:0]  unloaded_mask;
    } result_t;

endpackage

// ===== rtl/jds_table.sv =====
// per-drive state table: loaded side, spin-up and access times
module jds_table #(
    parameter int MAX_DRIVES = jds_pkg::MAX_DRIVES_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       fire,
    input  jds_pkg::tbl_upd_t                          upd,
    output logic [MAX_DRIVES-1:0]                      loaded,
    output logic [MAX_DRIVES-1:0][jds_pkg::ELEM_W-1:0] elem_arr,
    output logic [MAX_DRIVES-1:0]                      flip_arr,
    output logic [MAX_DRIVES-1:0][jds_pkg::TIME_W-1:0] spin_arr,
    output logic [MAX_DRIVES-1:0][jds_pkg::TIME_W-1:0] acc_arr
);
    import jds_pkg::*;

    localparam int IDX_W = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;

    logic [MAX_DRIVES-1:0]             loaded_reg, loaded_next;
    logic [MAX_DRIVES-1:0][ELEM_W-1:0] elem_reg, elem_next;
    logic [MAX_DRIVES-1:0]             flip_reg, flip_next;
    logic [MAX_DRIVES-1:0][TIME_W-1:0] spin_reg, spin_next;
    logic [MAX_DRIVES-1:0][TIME_W-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]                  idx;

    assign idx = upd.idx[IDX_W-1:0];

    always_comb
    begin
        loaded_next = loaded_reg;
        elem_next   = elem_reg;
        flip_next   = flip_reg;
        spin_next   = spin_reg;
        acc_next    = acc_reg;
        if (fire)
        begin
            loaded_next = loaded_reg & ~upd.unload[MAX_DRIVES-1:0];
            if (upd.load)
            begin
                loaded_next[idx] = 1'b1;
                elem_next[idx]   = upd.elem;
                flip_next[idx]   = upd.flip;
                spin_next[idx]   = upd.now;
                acc_next[idx]    = upd.now;
            end
            if (upd.touch)
            begin
                acc_next[idx] = upd.now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else
        begin
            loaded_reg <= loaded_next;
        end
    end

    // side data only counts while the loaded bit is set
    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        flip_reg <= flip_next;
        spin_reg <= spin_next;
        acc_reg  <= acc_next;
    end

    assign loaded   = loaded_reg;
    assign elem_arr = elem_reg;
    assign flip_arr = flip_reg;
    assign spin_arr = spin_reg;
    assign acc_arr  = acc_reg;

endmodule

// ===== rtl/jds_select.sv =====
// hit lookup, drive choice on a miss and idle probe for one request
module jds_select #(
    parameter int MAX_DRIVES = jds_pkg::MAX_DRIVES_DEF
) (
    input  jds_pkg::cfg_t                              cfg,
    input  logic                                       kind,
    input  logic [jds_pkg::ELEM_W-1:0]                 shelf_element,
    input  logic                                       side_flip,
    input  logic [jds_pkg::TIME_W-1:0]                 now_secs,
    input  logic [MAX_DRIVES-1:0]                      loaded,
    input  logic [MAX_DRIVES-1:0][jds_pkg::ELEM_W-1:0] elem_arr,
    input  logic [MAX_DRIVES-1:0]                      flip_arr,
    input  logic [MAX_DRIVES-1:0][jds_pkg::TIME_W-1:0] spin_arr,
    input  logic [MAX_DRIVES-1:0][jds_pkg::TIME_W-1:0] acc_arr,
    output jds_pkg::result_t                           res,
    output jds_pkg::tbl_upd_t                          upd
);
    import jds_pkg::*;

    localparam int IDX_W  = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;
    localparam int TREE_N = 1 << IDX_W;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] spin;
    } node_t;

    logic [COUNT_W-1:0]    n_eff;
    logic [MAX_DRIVES-1:0] in_use, hit_vec, match_vec, old_vec, empty_vec, idle_vec;
    logic [IDX_W-1:0]      hit_idx, match_idx, empty_idx, pick_idx;
    logic                  pick_ok;
    node_t                 node [1:2*TREE_N-1];

    always_comb
    begin
        n_eff = (cfg.drive_count > COUNT_W'(MAX_DRIVES)) ? COUNT_W'(MAX_DRIVES)
                                                         : cfg.drive_count;
        for (int i = 0; i < MAX_DRIVES; i++)
        begin
            in_use[i]    = COUNT_W'(i) < n_eff;
            hit_vec[i]   = loaded[i] && (elem_arr[i] == shelf_element)
                           && (flip_arr[i] == side_flip);
            match_vec[i] = in_use[i] && loaded[i] && (elem_arr[i] == shelf_element);
            // spin + hysteresis < now, kept 33 bits wide so nothing wraps
            old_vec[i]   = ({1'b0, spin_arr[i]} + {{(TIME_W-SECS_W+1){1'b0}}, cfg.hyst})
                           < {1'b0, now_secs};
            empty_vec[i] = in_use[i] && !loaded[i] && !cfg.offline[i] && cfg.present[i];
            idle_vec[i]  = loaded[i]
                           && (({1'b0, acc_arr[i]}
                                + {{(TIME_W-SECS_W+1){1'b0}}, cfg.timeout})
                               < {1'b0, now_secs});
        end
    end

    // first hit, first same-platter drive, last empty drive
    always_comb
    begin
        hit_idx   = '0;
        match_idx = '0;
        empty_idx = '0;
        for (int i = MAX_DRIVES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < MAX_DRIVES; i++)
        begin
            if (empty_vec[i])
            begin
                empty_idx = IDX_W'(i);
            end
        end
    end

    // oldest spin-up among displaceable drives, lower index wins ties
    always_comb
    begin
        for (int k = 0; k < TREE_N; k++)
        begin
            if (k < MAX_DRIVES)
            begin
                node[TREE_N+k].valid = in_use[k] && loaded[k] && old_vec[k];
                node[TREE_N+k].idx   = IDX_W'(k);
                node[TREE_N+k].spin  = spin_arr[k];
            end
            else
            begin
                node[TREE_N+k] = '0;
            end
        end
        for (int k = TREE_N - 1; k >= 1; k--)
        begin
            if (node[2*k+1].valid
                && (!node[2*k].valid || (node[2*k+1].spin < node[2*k].spin)))
            begin
                node[k] = node[2*k+1];
            end
            else
            begin
                node[k] = node[2*k];
            end
        end
    end

    always_comb
    begin
        res        = '0;
        res.status = ST_WAIT;
        upd        = '0;
        upd.elem   = shelf_element;
        upd.flip   = side_flip;
        upd.now    = now_secs;
        pick_ok    = 1'b0;
        pick_idx   = '0;
        if (kind)
        begin
            res.status        = ST_PROBE;
            res.unloaded_mask = MASK_W'(idle_vec);
            upd.unload        = MASK_W'(idle_vec);
        end
        else if (|hit_vec)
        begin
            res.status      = ST_HIT;
            res.drive_index = DRV_W'(hit_idx);
            upd.touch       = 1'b1;
            upd.idx         = DRV_W'(hit_idx);
        end
        else
        begin
            if (|match_vec)
            begin
                // other side of the same platter: displace it or wait
                pick_ok  = old_vec[match_idx];
                pick_idx = match_idx;
            end
            else if (|empty_vec)
            begin
                pick_ok  = 1'b1;
                pick_idx = empty_idx;
            end
            else
            begin
                pick_ok  = node[1].valid;
                pick_idx = node[1].idx;
            end
            if (pick_ok)
            begin
                upd.load        = 1'b1;
                upd.idx         = DRV_W'(pick_idx);
                res.drive_index = DRV_W'(pick_idx);
                if (loaded[pick_idx])
                begin
                    res.status          = ST_EVICT;
                    res.evicted_valid   = 1'b1;
                    res.evicted_element = elem_arr[pick_idx];
                    res.evicted_flip    = flip_arr[pick_idx];
                end
                else
                begin
                    res.status = ST_EMPTY;
                end
            end
        end
    end

endmodule

// ===== rtl/jukebox_drive_selector.sv =====
// Drive selector for a disc changer: takes one request per clock while the
// output is not stalled. A request is registered on acceptance, looked up
// against the drive table (16 entries by default) in the following cycle (hit
// search and drive choice are combinational, the table is written as the
// request moves on) and its result is registered, so the sustained rate is one
// request per cycle. A result waiting on a stalled output holds the request
// stage; configuration writes are registered before they take effect.
module jukebox_drive_selector #(
    parameter int MAX_DRIVES = jds_pkg::MAX_DRIVES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [jds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jds_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [jds_pkg::ELEM_W-1:0]        shelf_element,
    input  logic                              side_flip,
    input  logic [jds_pkg::TIME_W-1:0]        now_secs,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [jds_pkg::DRV_W-1:0]         drive_index,
    output logic                              evicted_valid,
    output logic [jds_pkg::ELEM_W-1:0]        evicted_element,
    output logic                              evicted_flip,
    output logic [jds_pkg::MASK_W-1:0]        unloaded_mask
);
    import jds_pkg::*;

    localparam int IDX_W = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;

    cfg_t              cfg_reg, cfg_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_kind_reg, s1_kind_next;
    logic [ELEM_W-1:0] s1_elem_reg, s1_elem_next;
    logic              s1_flip_reg, s1_flip_next;
    logic [TIME_W-1:0] s1_now_reg, s1_now_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;
    logic              s1_fire, in_fire;
    result_t           res;
    tbl_upd_t          upd;

    logic [MAX_DRIVES-1:0]             tbl_loaded;
    logic [MAX_DRIVES-1:0][ELEM_W-1:0] tbl_elem;
    logic [MAX_DRIVES-1:0]             tbl_flip;
    logic [MAX_DRIVES-1:0][TIME_W-1:0] tbl_spin;
    logic [MAX_DRIVES-1:0][TIME_W-1:0] tbl_acc;

    // request stage moves on when the result slot is free or being taken
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_DRIVE_COUNT: cfg_next.drive_count = cfg_data[COUNT_W-1:0];
                CFG_PRESENT:     cfg_next.present     = cfg_data;
                CFG_OFFLINE:     cfg_next.offline     = cfg_data;
                CFG_HYST:        cfg_next.hyst        = cfg_data;
                CFG_TIMEOUT:     cfg_next.timeout     = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);
        s1_kind_next  = in_fire ? kind          : s1_kind_reg;
        s1_elem_next  = in_fire ? shelf_element : s1_elem_reg;
        s1_flip_next  = in_fire ? side_flip     : s1_flip_reg;
        s1_now_next   = in_fire ? now_secs      : s1_now_reg;
        out_valid_next = s1_fire || (out_valid_reg && out_stall);
        res_next       = s1_fire ? res : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_count <= DRIVE_COUNT_RST;
            cfg_reg.present     <= PRESENT_RST;
            cfg_reg.offline     <= OFFLINE_RST;
            cfg_reg.hyst        <= HYST_RST;
            cfg_reg.timeout     <= TIMEOUT_RST;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= s1_kind_next;
        s1_elem_reg <= s1_elem_next;
        s1_flip_reg <= s1_flip_next;
        s1_now_reg  <= s1_now_next;
        res_reg     <= res_next;
    end

    jds_select #(
        .MAX_DRIVES (MAX_DRIVES)
    ) u_select (
        .cfg           (cfg_reg),
        .kind          (s1_kind_reg),
        .shelf_element (s1_elem_reg),
        .side_flip     (s1_flip_reg),
        .now_secs      (s1_now_reg),
        .loaded        (tbl_loaded),
        .elem_arr      (tbl_elem),
        .flip_arr      (tbl_flip),
        .spin_arr      (tbl_spin),
        .acc_arr       (tbl_acc),
        .res           (res),
        .upd           (upd)
    );

    jds_table #(
        .MAX_DRIVES (MAX_DRIVES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (s1_fire),
        .upd      (upd),
        .loaded   (tbl_loaded),
        .elem_arr (tbl_elem),
        .flip_arr (tbl_flip),
        .spin_arr (tbl_spin),
        .acc_arr  (tbl_acc)
    );

    assign out_valid       = out_valid_reg;
    assign status          = res_reg.status;
    assign drive_index     = res_reg.drive_index;
    assign evicted_valid   = res_reg.evicted_valid;
    assign evicted_element = res_reg.evicted_element;
    assign evicted_flip    = res_reg.evicted_flip;
    assign unloaded_mask   = res_reg.unloaded_mask;

    // an occupant is reported exactly when the result is an eviction
    a_evict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.evicted_valid == (res_reg.status == ST_EVICT)))
        else $error("evicted flag disagrees with status");

    // only a probe unloads idle sides
    a_mask_probe_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status != ST_PROBE) |-> (res_reg.unloaded_mask == '0))
        else $error("unload mask set on an access result");

    // a drive chosen for a new side is loaded afterwards
    a_load_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && upd.load |=> tbl_loaded[$past(upd.idx[IDX_W-1:0])])
        else $error("chosen drive not marked loaded");

endmodule

// ===== sim/tb_jukebox_drive_selector.sv =====
// testbench for jukebox_drive_selector: directed and random requests checked against a drive policy model
module tb_jukebox_drive_selector;
    import jds_pkg::*;

    localparam int NUM_DRIVES  = MAX_DRIVES_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 133;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [ELEM_W-1:0]     shelf_element;
    logic                  side_flip;
    logic [TIME_W-1:0]     now_secs;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            status;
    logic [DRV_W-1:0]      drive_index;
    logic                  evicted_valid;
    logic [ELEM_W-1:0]     evicted_element;
    logic                  evicted_flip;
    logic [MASK_W-1:0]     unloaded_mask;

    // policy model: configuration and per-drive table
    logic [COUNT_W-1:0]    drives_in_use;
    logic [MASK_W-1:0]     present_bits;
    logic [MASK_W-1:0]     offline_bits;
    logic [SECS_W-1:0]     hyst_secs;
    logic [SECS_W-1:0]     timeout_secs;
    bit                    drive_full   [NUM_DRIVES];
    logic [ELEM_W-1:0]     held_element [NUM_DRIVES];
    logic                  held_flip    [NUM_DRIVES];
    longint                spun_up_at   [NUM_DRIVES];
    longint                touched_at   [NUM_DRIVES];

    result_t               pending_results[$];
    int                    mismatch_count;
    int                    idle_cycles;
    bit                    gaps_on;
    int                    burst_left;
    int                    stall_mode;
    int                    stall_phase;
    logic [TIME_W-1:0]     wall_secs;

    jukebox_drive_selector DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .shelf_element   (shelf_element),
        .side_flip       (side_flip),
        .now_secs        (now_secs),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .drive_index     (drive_index),
        .evicted_valid   (evicted_valid),
        .evicted_element (evicted_element),
        .evicted_flip    (evicted_flip),
        .unloaded_mask   (unloaded_mask)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // applies one request to the drive table and returns the answer it should get
    function automatic result_t choose_drive(logic probe, logic [ELEM_W-1:0] elem, logic flip,
                                             logic [TIME_W-1:0] now);
        result_t r;
        longint  now_l;
        longint  cutoff;
        longint  best;
        int      n;
        int      pick;
        r = '0;
        now_l = now;
        if (probe)
        begin
            cutoff = now_l - longint'(timeout_secs);
            for (int i = 0; i < NUM_DRIVES; i++)
            begin
                if (drive_full[i] && cutoff > touched_at[i])
                begin
                    drive_full[i] = 1'b0;
                    r.unloaded_mask[i] = 1'b1;
                end
            end
            r.status = ST_PROBE;
            return r;
        end
        // hits look at every drive, even beyond the count in use
        for (int i = 0; i < NUM_DRIVES; i++)
        begin
            if (drive_full[i] && held_element[i] == elem && held_flip[i] == flip)
            begin
                touched_at[i] = now_l;
                r.status = ST_HIT;
                r.drive_index = DRV_W'(i);
                return r;
            end
        end
        n = (drives_in_use > NUM_DRIVES) ? NUM_DRIVES : int'(drives_in_use);
        cutoff = now_l - longint'(hyst_secs);
        best = cutoff;
        pick = -1;
        for (int i = 0; i < n; i++)
        begin
            if (!drive_full[i])
            begin
                if (!offline_bits[i] && present_bits[i])
                begin
                    pick = i;
                    best = 0;
                end
            end
            else if (held_element[i] == elem)
            begin
                // other side of the same platter decides alone
                pick = (spun_up_at[i] < cutoff) ? i : -1;
                break;
            end
            else if (spun_up_at[i] < best)
            begin
                pick = i;
                best = spun_up_at[i];
            end
        end
        if (pick < 0)
        begin
            r.status = ST_WAIT;
            return r;
        end
        if (drive_full[pick])
        begin
            r.status = ST_EVICT;
            r.evicted_valid = 1'b1;
            r.evicted_element = held_element[pick];
            r.evicted_flip = held_flip[pick];
        end
        else
        begin
            r.status = ST_EMPTY;
        end
        r.drive_index = DRV_W'(pick);
        drive_full[pick] = 1'b1;
        held_element[pick] = elem;
        held_flip[pick] = flip;
        spun_up_at[pick] = now_l;
        touched_at[pick] = now_l;
        return r;
    endfunction

    task automatic send_request(logic probe, logic [ELEM_W-1:0] elem, logic flip,
                                logic [TIME_W-1:0] now);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 24 : 5)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        kind          <= probe;
        shelf_element <= elem;
        side_flip     <= flip;
        now_secs      <= now;
        in_valid      <= 1'b1;
        do @(negedge clk); while (in_stall);
        pending_results.push_back(choose_drive(probe, elem, flip, now));
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_config(logic [COUNT_W-1:0] cnt, logic [MASK_W-1:0] pres,
                               logic [MASK_W-1:0] offl, logic [SECS_W-1:0] hy,
                               logic [SECS_W-1:0] idle_lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DRIVE_COUNT;
        cfg_data  <= CFG_DATA_W'(cnt);
        @(posedge clk);
        cfg_index <= CFG_PRESENT;
        cfg_data  <= pres;
        @(posedge clk);
        cfg_index <= CFG_OFFLINE;
        cfg_data  <= offl;
        @(posedge clk);
        cfg_index <= CFG_HYST;
        cfg_data  <= hy;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= idle_lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        drives_in_use = cnt;
        present_bits  = pres;
        offline_bits  = offl;
        hyst_secs     = hy;
        timeout_secs  = idle_lim;
    endtask

    // reset settings: fill from the top, hit, other side inside and past hysteresis, probes
    task automatic test_selection_order();
        send_request(1'b0, 16'h0000, 1'b0, 32'd0);
        send_request(1'b0, 16'h0000, 1'b0, 32'd5);
        send_request(1'b0, 16'h0000, 1'b1, 32'd8);
        send_request(1'b0, 16'h0000, 1'b1, 32'd11);
        send_request(1'b0, 16'hFFFF, 1'b1, 32'd20);
        send_request(1'b0, 16'h1234, 1'b0, 32'd21);
        send_request(1'b1, 16'h0000, 1'b0, 32'd100);
        send_request(1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 16'hABCD, 1'b0, 32'd0);
    endtask

    // small drive counts, a count of zero and above the maximum, mask and time extremes
    task automatic test_register_extremes();
        stall_mode = 1;
        wait_idle();
        load_config(5'd2, 16'hFFFF, 16'h0000, 16'd0, 16'd0);
        send_request(1'b0, 16'h0001, 1'b0, 32'd100);
        send_request(1'b0, 16'h0002, 1'b0, 32'd101);
        send_request(1'b0, 16'h0003, 1'b0, 32'd102);
        send_request(1'b0, 16'hFFFF, 1'b1, 32'd103);
        send_request(1'b1, 16'h0000, 1'b0, 32'd103);
        wait_idle();
        load_config(5'd0, 16'hFFFF, 16'h0000, 16'd10, 16'd600);
        send_request(1'b0, 16'h0004, 1'b0, 32'd200);
        send_request(1'b0, 16'hFFFF, 1'b1, 32'd201);
        wait_idle();
        load_config(5'd31, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(1'b0, 16'h0005, 1'b1, 32'd300);
        send_request(1'b0, 16'h0005, 1'b1, 32'hFFFF_FFFF);
        send_request(1'b1, 16'h0000, 1'b0, 32'h0001_0300);
        wait_idle();
        load_config(5'd16, 16'h00FF, 16'h000F, 16'd1, 16'd600);
        send_request(1'b0, 16'h0006, 1'b0, 32'd400);
        send_request(1'b0, 16'h0007, 1'b1, 32'd401);
        send_request(1'b1, 16'h0000, 1'b0, 32'hFFFF_FFFF);
        send_request(1'b0, 16'h0000, 1'b0, 32'd0);
    endtask

    // phases of random traffic on a small element pool so hits, other sides and evictions recur
    task automatic test_random_traffic();
        logic [ELEM_W-1:0]  pool [6];
        logic [COUNT_W-1:0] cnt;
        logic [MASK_W-1:0]  pres;
        logic [MASK_W-1:0]  offl;
        logic [SECS_W-1:0]  hy;
        logic [SECS_W-1:0]  idle_lim;
        logic [ELEM_W-1:0]  elem;
        int                 roll;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    cnt = 5'd16; pres = 16'hFFFF; offl = 16'h0000; hy = 16'd10; idle_lim = 16'd600;
                end
                1:
                begin
                    cnt = 5'd31; pres = 16'($urandom); offl = 16'($urandom);
                    hy = 16'd0; idle_lim = 16'd0;
                end
                2:
                begin
                    cnt = 5'd0; pres = 16'hFFFF; offl = 16'h0000; hy = 16'd5; idle_lim = 16'hFFFF;
                end
                3:
                begin
                    cnt = 5'd1; pres = 16'($urandom); offl = 16'h0000;
                    hy = 16'hFFFF; idle_lim = 16'hFFFF;
                end
                4:
                begin
                    cnt = 5'($urandom_range(1, 16)); pres = 16'h0000; offl = 16'h0000;
                    hy = 16'd3; idle_lim = 16'd200;
                end
                5:
                begin
                    cnt = 5'd16; pres = 16'hFFFF; offl = 16'hFFFF; hy = 16'd20; idle_lim = 16'd50;
                end
                default:
                begin
                    cnt = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
                    pres = 16'($urandom | $urandom);
                    offl = 16'($urandom & $urandom);
                    hy = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
                    idle_lim = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 900));
                end
            endcase
            wait_idle();
            load_config(cnt, pres, offl, hy, idle_lim);
            gaps_on = (p % 3 != 0);
            stall_mode = p % 4;
            foreach (pool[j])
                pool[j] = 16'($urandom);
            if (p == 0)
            begin
                pool[0] = '0;
                pool[1] = '1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // time mostly creeps, sometimes crosses hysteresis or timeout, rarely jumps anywhere
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    wall_secs += $urandom_range(0, 3);
                else if (roll < 85)
                    wall_secs += $urandom_range(0, hy + 1);
                else if (roll < 97)
                    wall_secs += $urandom_range(0, idle_lim + 1);
                else
                    wall_secs = $urandom;
                elem = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, 5)];
                send_request($urandom_range(0, 99) < 8, elem, 1'($urandom), wall_secs);
            end
        end
    endtask

    always @(posedge clk)
    begin
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 70);
            3:
            begin
                stall_phase = (stall_phase + 1) % 11;
                out_stall <= (stall_phase < 4);
            end
            default: out_stall <= 1'b0;
        endcase
    end

    // handshakes are judged at the falling edge, where all signals have settled
    always @(negedge clk)
    begin : check_results
        result_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: status %0d drive %0d mask %h",
                                 status, drive_index, unloaded_mask);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || drive_index !== want.drive_index ||
                        evicted_valid !== want.evicted_valid ||
                        evicted_element !== want.evicted_element ||
                        evicted_flip !== want.evicted_flip ||
                        unloaded_mask !== want.unloaded_mask)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected st %0d drv %0d ev %0b %h %0b mask %h, got st %0d drv %0d ev %0b %h %0b mask %h",
                                     want.status, want.drive_index, want.evicted_valid,
                                     want.evicted_element, want.evicted_flip, want.unloaded_mask,
                                     status, drive_index, evicted_valid, evicted_element,
                                     evicted_flip, unloaded_mask);
                        mismatch_count++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_DRIVE_COUNT;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        kind          <= 1'b0;
        shelf_element <= '0;
        side_flip     <= 1'b0;
        now_secs      <= '0;
        out_stall     <= 1'b0;
        rst_n         <= 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        gaps_on        = 1'b0;
        burst_left     = 0;
        stall_mode     = 0;
        stall_phase    = 0;
        wall_secs      = '0;
        drives_in_use  = DRIVE_COUNT_RST;
        present_bits   = PRESENT_RST;
        offline_bits   = OFFLINE_RST;
        hyst_secs      = HYST_RST;
        timeout_secs   = TIMEOUT_RST;
        for (int i = 0; i < NUM_DRIVES; i++)
        begin
            drive_full[i]   = 1'b0;
            held_element[i] = '0;
            held_flip[i]    = 1'b0;
            spun_up_at[i]   = 0;
            touched_at[i]   = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_selection_order();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
